FILE: sv/imucf_pkg.sv
package imucf_pkg;

    // Operation codes carried by an input transaction.
    localparam logic [1:0] OP_SAMPLE     = 2'd0;
    localparam logic [1:0] OP_LOAD_GYRO  = 2'd1;
    localparam logic [1:0] OP_LOAD_FUSED = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_BLEND_WEIGHT  = 2'd0;
    localparam logic [1:0] CFG_RATE_DEADBAND = 2'd1;
    localparam logic [1:0] CFG_STEP_SCALE    = 2'd2;

    // Configuration reset values.
    localparam logic [15:0] BLEND_WEIGHT_RST  = 16'd63013;
    localparam logic [15:0] RATE_DEADBAND_RST = 16'd128;
    localparam logic [15:0] STEP_SCALE_RST    = 16'd655;

    // How a lane updates its angle registers at the end of a transaction.
    typedef enum logic [1:0] {
        C_NONE       = 2'd0,
        C_SAMPLE     = 2'd1,
        C_LOAD_GYRO  = 2'd2,
        C_LOAD_FUSED = 2'd3
    } t_commit;

    // Step controls from the sequencer to each axis lane.
    typedef struct packed {
        logic    mul_en;
        logic    add_en;
        logic    mulb_en;
        logic    use_blend;
        t_commit commit;
    } t_lane_ctl;

endpackage

FILE: sv/imu_complementary_attitude_filter_top.sv
// A gyro sample passes through the rate multiply, add, blend multiply and clamp steps
// in each axis lane before its result commits; a load or a sample without gyro rates
// goes straight to the commit. A new input is taken only once the result has committed,
// and the commit waits while a previous result is still valid and not yet accepted.
// Reset (synchronous, active low) clears all angles and held accelerometer values
// and loads the configuration defaults.
module imu_complementary_attitude_filter_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_opcode,
    input  logic               i_gyro_valid,
    input  logic               i_acc_valid,
    input  logic signed [19:0] i_roll_in,
    input  logic signed [19:0] i_pitch_in,
    input  logic signed [19:0] i_yaw_in,
    input  logic signed [16:0] i_acc_roll,
    input  logic signed [16:0] i_acc_pitch,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_gyro_roll_angle,
    output logic signed [31:0] o_gyro_pitch_angle,
    output logic signed [31:0] o_gyro_yaw_angle,
    output logic signed [31:0] o_fused_roll_angle,
    output logic signed [31:0] o_fused_pitch_angle,
    output logic signed [31:0] o_fused_yaw_angle
);
    import imucf_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_ADD  = 5'b00100,
        S_MULB = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [15:0]        r_blend_weight;
    logic [15:0]        r_rate_deadband;
    logic [15:0]        r_step_scale;
    logic [1:0]         r_op;
    logic               r_gyro_valid;
    logic signed [19:0] r_roll;
    logic signed [19:0] r_pitch;
    logic signed [19:0] r_yaw;
    logic signed [16:0] r_held_roll;
    logic signed [16:0] r_held_pitch;
    logic               r_out_valid;

    logic               in_accept;
    logic               out_free;
    logic               commit_now;
    logic [19:0]        yaw_mag;
    logic               yaw_small;
    logic signed [19:0] yaw_eff;
    t_commit            commit;
    t_lane_ctl          ctl_blend;
    t_lane_ctl          ctl_yaw;

    assign in_accept  = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign commit_now = (r_state == S_FIN) && out_free;

    // Yaw deadband applies only to gyro samples; loads take the raw value.
    assign yaw_mag   = i_yaw_in[19] ? (~i_yaw_in + 20'd1) : i_yaw_in;
    assign yaw_small = yaw_mag < {4'd0, r_rate_deadband};
    assign yaw_eff   = ((i_opcode == OP_SAMPLE) && yaw_small) ? 20'sd0 : i_yaw_in;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_weight  <= BLEND_WEIGHT_RST;
            r_rate_deadband <= RATE_DEADBAND_RST;
            r_step_scale    <= STEP_SCALE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BLEND_WEIGHT:  r_blend_weight  <= i_cfg_data;
                CFG_RATE_DEADBAND: r_rate_deadband <= i_cfg_data;
                CFG_STEP_SCALE:    r_step_scale    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Input capture for the transaction in flight.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op         <= i_opcode;
            r_gyro_valid <= i_gyro_valid;
            r_roll       <= i_roll_in;
            r_pitch      <= i_pitch_in;
            r_yaw        <= yaw_eff;
        end
    end

    // Held accelerometer angles are refreshed before the blend uses them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_roll  <= '0;
            r_held_pitch <= '0;
        end else if (in_accept && (i_opcode == OP_SAMPLE) && i_acc_valid) begin
            r_held_roll  <= i_acc_roll;
            r_held_pitch <= i_acc_pitch;
        end
    end

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if ((i_opcode == OP_SAMPLE) && i_gyro_valid) begin
                        n_state = S_MUL;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_MUL:  n_state = S_ADD;
            S_ADD:  n_state = S_MULB;
            S_MULB: n_state = S_FIN;
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Commit kind for the lanes at the end of the transaction.
    always_comb begin
        commit = C_NONE;
        if (commit_now) begin
            case (r_op)
                OP_SAMPLE:     commit = r_gyro_valid ? C_SAMPLE : C_NONE;
                OP_LOAD_GYRO:  commit = C_LOAD_GYRO;
                OP_LOAD_FUSED: commit = C_LOAD_FUSED;
                default:       commit = C_NONE;
            endcase
        end
    end

    always_comb begin
        ctl_blend.mul_en    = (r_state == S_MUL);
        ctl_blend.add_en    = (r_state == S_ADD);
        ctl_blend.mulb_en   = (r_state == S_MULB);
        ctl_blend.use_blend = 1'b1;
        ctl_blend.commit    = commit;
        ctl_yaw             = ctl_blend;
        ctl_yaw.use_blend   = 1'b0;
    end

    // Axis lanes working side by side.
    imucf_lane u_lane_roll (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl_blend),
        .i_value        (r_roll),
        .i_held         (r_held_roll),
        .i_blend_weight (r_blend_weight),
        .i_step_scale   (r_step_scale),
        .o_gyro_angle   (o_gyro_roll_angle),
        .o_fused_angle  (o_fused_roll_angle)
    );

    imucf_lane u_lane_pitch (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl_blend),
        .i_value        (r_pitch),
        .i_held         (r_held_pitch),
        .i_blend_weight (r_blend_weight),
        .i_step_scale   (r_step_scale),
        .o_gyro_angle   (o_gyro_pitch_angle),
        .o_fused_angle  (o_fused_pitch_angle)
    );

    imucf_lane u_lane_yaw (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl_yaw),
        .i_value        (r_yaw),
        .i_held         (17'sd0),
        .i_blend_weight (r_blend_weight),
        .i_step_scale   (r_step_scale),
        .o_gyro_angle   (o_gyro_yaw_angle),
        .o_fused_angle  (o_fused_yaw_angle)
    );

    // Result valid; the lane angles stay put until the next commit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit_now) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

FILE: sv/imucf_lane.sv
module imucf_lane (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  imucf_pkg::t_lane_ctl i_ctl,
    input  logic signed [19:0]   i_value,
    input  logic signed [16:0]   i_held,
    input  logic [15:0]          i_blend_weight,
    input  logic [15:0]          i_step_scale,
    output logic signed [31:0]   o_gyro_angle,
    output logic signed [31:0]   o_fused_angle
);
    import imucf_pkg::*;

    localparam int PROD_W = 37;
    localparam int SUM_W  = 34;
    localparam int PW_W   = 51;
    localparam int PH_W   = 35;
    localparam int TOT_W  = 52;

    // Clamp a wide signed value to the 32-bit signed range.
    function automatic logic signed [31:0] f_sat32(input logic signed [TOT_W-1:0] v);
        logic [TOT_W-32:0] hi;
        hi = v[TOT_W-1:31];
        if ((&hi) || (~|hi)) begin
            return v[31:0];
        end else if (v[TOT_W-1]) begin
            return 32'sh8000_0000;
        end else begin
            return 32'sh7fff_ffff;
        end
    endfunction

    logic signed [PROD_W-1:0] r_prod;
    logic signed [SUM_W-1:0]  r_gyro_sum;
    logic signed [SUM_W-1:0]  r_fsum;
    logic signed [PW_W-1:0]   r_pw;
    logic signed [PH_W-1:0]   r_ph;
    logic signed [31:0]       r_gyro;
    logic signed [31:0]       r_fused;

    logic signed [20:0]       inc;
    logic signed [SUM_W-1:0]  n_gyro_sum;
    logic signed [SUM_W-1:0]  n_fsum;
    logic [16:0]              acc_weight;
    logic signed [TOT_W-1:0]  blend_total;
    logic signed [TOT_W-1:0]  blend_shift;
    logic signed [31:0]       gyro_sat;
    logic signed [31:0]       fused_sum_sat;
    logic signed [31:0]       fused_blend_sat;
    logic signed [31:0]       load_value;

    // Angle increment: floor of rate times step scale over 2^16.
    assign inc = r_prod[PROD_W-1:16];

    // Gyro and fused sums at full width, before clamping.
    assign n_gyro_sum = {{(SUM_W-32){r_gyro[31]}}, r_gyro}
                      + {{(SUM_W-21){inc[20]}}, inc};
    assign n_fsum     = {{(SUM_W-32){r_fused[31]}}, r_fused}
                      + {{(SUM_W-21){inc[20]}}, inc};

    // Accelerometer weight is 2^16 minus the gyro weight.
    assign acc_weight = 17'h1_0000 - {1'b0, i_blend_weight};

    // Weighted sum, floor shift and clamp.
    assign blend_total = {{(TOT_W-PW_W){r_pw[PW_W-1]}}, r_pw}
                       + {{(TOT_W-PH_W){r_ph[PH_W-1]}}, r_ph};
    assign blend_shift = {{16{blend_total[TOT_W-1]}}, blend_total[TOT_W-1:16]};

    assign gyro_sat        = f_sat32({{(TOT_W-SUM_W){r_gyro_sum[SUM_W-1]}}, r_gyro_sum});
    assign fused_sum_sat   = f_sat32({{(TOT_W-SUM_W){r_fsum[SUM_W-1]}}, r_fsum});
    assign fused_blend_sat = f_sat32(blend_shift);
    assign load_value      = {{12{i_value[19]}}, i_value};

    // Datapath registers: each multiply is followed by a register.
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= PROD_W'(i_value) * PROD_W'($signed({1'b0, i_step_scale}));
        end
        if (i_ctl.add_en) begin
            r_gyro_sum <= n_gyro_sum;
            r_fsum     <= n_fsum;
        end
        if (i_ctl.mulb_en) begin
            r_pw <= PW_W'(r_fsum) * PW_W'($signed({1'b0, i_blend_weight}));
            r_ph <= PH_W'(i_held) * PH_W'($signed({1'b0, acc_weight}));
        end
    end

    // Angle state, updated at most once per transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gyro  <= '0;
            r_fused <= '0;
        end else begin
            case (i_ctl.commit)
                C_SAMPLE: begin
                    r_gyro  <= gyro_sat;
                    r_fused <= i_ctl.use_blend ? fused_blend_sat : fused_sum_sat;
                end
                C_LOAD_GYRO: begin
                    r_gyro <= load_value;
                end
                C_LOAD_FUSED: begin
                    r_fused <= load_value;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_gyro_angle  = r_gyro;
    assign o_fused_angle = r_fused;

endmodule
